[design/css_pkg.sv]
// Shared types and constants for the composite sync sequencer.
// No dependencies; used by css_step and composite_sync_sequencer_core.
package css_pkg;

  // configuration register indexes
  localparam logic [2:0] RegHsyncPeriod     = 3'd0;
  localparam logic [2:0] RegHalfSyncPeriod  = 3'd1;
  localparam logic [2:0] RegVsyncPeriod     = 3'd2;
  localparam logic [2:0] RegBackPorchPeriod = 3'd3;
  localparam logic [2:0] RegActivePeriod    = 3'd4;
  localparam logic [2:0] RegFirstVisLine    = 3'd5;
  localparam logic [2:0] RegLastLine        = 3'd6;

  // line ranges of the vertical interval
  localparam int unsigned VsyncLastLine = 3;
  localparam int unsigned EqualLastLine = 6;
  localparam int unsigned FieldLastLine = 9;

  // vertical sub-step codes
  localparam logic [1:0] VstepFirst = 2'd0;
  localparam logic [1:0] VstepLast  = 2'd3;

  // horizontal sub-step codes
  localparam logic [1:0] HstepSync   = 2'd1;
  localparam logic [1:0] HstepPorch  = 2'd2;
  localparam logic [1:0] HstepActive = 2'd3;

  // reset values of the configuration registers
  localparam logic [15:0] HsyncPeriodRst     = 16'd94;
  localparam logic [15:0] HalfSyncPeriodRst  = 16'd47;
  localparam logic [15:0] VsyncPeriodRst     = 16'd520;
  localparam logic [15:0] BackPorchPeriodRst = 16'd160;
  localparam logic [15:0] ActivePeriodRst    = 16'd1010;
  localparam logic [9:0]  FirstVisLineRst    = 10'd20;
  localparam logic [9:0]  LastLineRst        = 10'd220;

  typedef struct packed {
    logic [15:0] hsync_period;
    logic [15:0] half_sync_period;
    logic [15:0] vsync_period;
    logic [15:0] back_porch_period;
    logic [15:0] active_period;
    logic [9:0]  first_visible_line;
    logic [9:0]  last_line;
  } css_cfg_t;

  // sequencer control state apart from the line counter
  typedef struct packed {
    logic [1:0] vert_step;
    logic [1:0] horiz_step;
    logic       sync;
    logic       mark;
  } css_ctl_t;

  typedef struct packed {
    logic [15:0] next_period;
    logic        sync_level;
    logic        field_mark;
    logic        start_burst;
    logic [9:0]  line_number;
  } css_res_t;

endpackage

[design/css_step.sv]
// Next-state and result logic for one timer expiry of the sync sequencer.
// Depends on css_pkg.
module css_step #(
  parameter int unsigned LINE_BITS = 10
) (
  input  css_pkg::css_cfg_t     cfg_i,
  input  logic [LINE_BITS-1:0]  line_i,
  input  css_pkg::css_ctl_t     ctl_i,
  output logic [LINE_BITS-1:0]  line_o,
  output css_pkg::css_ctl_t     ctl_o,
  output css_pkg::css_res_t     res_o
);
  import css_pkg::*;

  localparam int unsigned CmpW = (LINE_BITS > 10) ? LINE_BITS : 10;

  logic [LINE_BITS-1:0] line_inc;
  logic [CmpW-1:0]      line_ext;
  logic [15:0]          period;
  logic                 burst;

  assign line_inc = line_i + {{(LINE_BITS-1){1'b0}}, 1'b1};
  assign line_ext = CmpW'(line_i);

  // walk the vertical interval or the parts of a visible line
  always_comb begin
    line_o = line_i;
    ctl_o  = ctl_i;
    period = cfg_i.active_period;
    burst  = 1'b0;
    if (line_i <= LINE_BITS'(VsyncLastLine)) begin
      // vertical sync pulses
      ctl_o.mark      = 1'b1;
      period          = ctl_i.vert_step[0] ? cfg_i.vsync_period : cfg_i.half_sync_period;
      ctl_o.sync      = ctl_i.vert_step[0];
      ctl_o.vert_step = ctl_i.vert_step + 2'd1;
      if (ctl_i.vert_step == VstepLast) begin
        line_o = line_inc;
      end
    end else if (line_i <= LINE_BITS'(EqualLastLine)) begin
      // equalizing pulses
      ctl_o.mark      = 1'b0;
      period          = ctl_i.vert_step[0] ? cfg_i.hsync_period : cfg_i.vsync_period;
      ctl_o.sync      = ctl_i.vert_step[0];
      ctl_o.vert_step = ctl_i.vert_step + 2'd1;
      if (ctl_i.vert_step == VstepLast) begin
        line_o = line_inc;
      end
    end else if (line_i <= LINE_BITS'(FieldLastLine)) begin
      // two steps a line, sync stays low on the second
      if (ctl_i.vert_step == VstepFirst) begin
        period          = cfg_i.half_sync_period;
        ctl_o.sync      = 1'b0;
        ctl_o.vert_step = 2'd1;
      end else begin
        period          = cfg_i.vsync_period;
        ctl_o.mark      = 1'b1;
        ctl_o.vert_step = VstepFirst;
        line_o          = line_inc;
      end
    end else begin
      // hsync, back porch, pixels
      ctl_o.mark = 1'b0;
      case (ctl_i.horiz_step)
        HstepSync: begin
          period           = cfg_i.hsync_period;
          ctl_o.sync       = 1'b0;
          ctl_o.horiz_step = HstepPorch;
        end
        HstepPorch: begin
          period           = cfg_i.back_porch_period;
          ctl_o.sync       = 1'b1;
          ctl_o.horiz_step = HstepActive;
        end
        default: begin
          period           = cfg_i.active_period;
          ctl_o.sync       = 1'b1;
          burst            = (line_ext >= CmpW'(cfg_i.first_visible_line));
          ctl_o.horiz_step = HstepSync;
          if (line_ext == CmpW'(cfg_i.last_line)) begin
            line_o = LINE_BITS'(1);
          end else begin
            line_o = line_inc;
          end
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    res_o.next_period = period;
    res_o.sync_level  = ctl_o.sync;
    res_o.field_mark  = ctl_o.mark;
    res_o.start_burst = burst;
    res_o.line_number = 10'(line_i);
  end

endmodule

[design/composite_sync_sequencer_core.sv]
// Composite video sync sequencer: top level with config registers and pipeline.
// Depends on css_pkg and css_step.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, tick_i                 | input
//  out     | out_valid_o, out_ready_i, next_period_o,       | output
//          | sync_level_o, field_mark_o, start_burst_o,     |
//          | line_number_o                                  |
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,         | input
//          | cfg_data_i                                     |
//
// One item per cycle sustained while the output is not stalled; the result goes through
// the input register, then next-state logic into the result register.
// The line and step state updates in the cycle an item leaves the input register.
// A tick of 0 passes without a result and without a state change.
// Output stalls back up into the input register only when a result is waiting.
// Reset returns control state to line 1 and the first steps and loads the default periods and line limits.
module composite_sync_sequencer_core #(
  parameter int unsigned LINE_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        tick_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] next_period_o,
  output logic        sync_level_o,
  output logic        field_mark_o,
  output logic        start_burst_o,
  output logic [9:0]  line_number_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import css_pkg::*;

  css_cfg_t             cfg_q;
  logic [LINE_BITS-1:0] line_q, line_d;
  css_ctl_t             ctl_q, ctl_d;
  logic                 s1_valid_q;
  logic                 s1_tick_q;
  logic                 s1_adv;
  logic                 step_fire;
  logic                 out_valid_q;
  css_res_t             res_d, res_q;

  // configuration writes, always accepted
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hsync_period       <= HsyncPeriodRst;
      cfg_q.half_sync_period   <= HalfSyncPeriodRst;
      cfg_q.vsync_period       <= VsyncPeriodRst;
      cfg_q.back_porch_period  <= BackPorchPeriodRst;
      cfg_q.active_period      <= ActivePeriodRst;
      cfg_q.first_visible_line <= FirstVisLineRst;
      cfg_q.last_line          <= LastLineRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegHsyncPeriod:     cfg_q.hsync_period       <= cfg_data_i;
        RegHalfSyncPeriod:  cfg_q.half_sync_period   <= cfg_data_i;
        RegVsyncPeriod:     cfg_q.vsync_period       <= cfg_data_i;
        RegBackPorchPeriod: cfg_q.back_porch_period  <= cfg_data_i;
        RegActivePeriod:    cfg_q.active_period      <= cfg_data_i;
        RegFirstVisLine:    cfg_q.first_visible_line <= cfg_data_i[9:0];
        RegLastLine:        cfg_q.last_line          <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // input register advances unless a tick would overwrite a waiting result
  assign s1_adv     = s1_valid_q && (!s1_tick_q || !out_valid_q || out_ready_i);
  assign step_fire  = s1_adv && s1_tick_q;
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_tick_q <= tick_i;
    end
  end

  // sequencer step logic
  css_step #(
    .LINE_BITS(LINE_BITS)
  ) u_step (
    .cfg_i (cfg_q),
    .line_i(line_q),
    .ctl_i (ctl_q),
    .line_o(line_d),
    .ctl_o (ctl_d),
    .res_o (res_d)
  );

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q           <= LINE_BITS'(1);
      ctl_q.vert_step  <= VstepFirst;
      ctl_q.horiz_step <= HstepSync;
      ctl_q.sync       <= 1'b0;
      ctl_q.mark       <= 1'b0;
    end else if (step_fire) begin
      line_q <= line_d;
      ctl_q  <= ctl_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_period_o = res_q.next_period;
  assign sync_level_o  = res_q.sync_level;
  assign field_mark_o  = res_q.field_mark;
  assign start_burst_o = res_q.start_burst;
  assign line_number_o = res_q.line_number;

`ifndef SYNTH
  // a burst only starts on an active segment, outside vertical sync
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && start_burst_o) |-> (sync_level_o && !field_mark_o))
    else $error("burst outside active segment");

  // backpressure only while an item is held in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s1_tick_q && out_valid_q))
    else $error("input stalled without a waiting result");

  // line counter moves only when a tick is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_fire |=> $stable(line_q))
    else $error("line counter changed without a tick");
`endif

endmodule

[tb/css_sync_checker.sv]
// Checker for the composite sync sequencer: watches the config, tick and result channels.
// Keeps its own copy of the sequencer state and compares every result field.
// Depends on css_pkg for the register indexes, step codes and result struct.
module css_sync_checker
  import css_pkg::*;
#(
  parameter int unsigned LINE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               tick_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [15:0]        next_period_i,
  input  logic               sync_level_i,
  input  logic               field_mark_i,
  input  logic               start_burst_i,
  input  logic [9:0]         line_number_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        steps_outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PrintLimit = 100;

  css_cfg_t             cfg_q;
  logic [LINE_BITS-1:0] line_q;
  css_ctl_t             ctl_q;
  css_res_t             expected_steps[$];
  css_res_t             want_res;

  // one line per mismatch, log capped so a broken block cannot flood it
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count_o++;
    if (mismatch_count_o <= PrintLimit) begin
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  // advance the sequencer by one timer expiry and build the result it gives
  task automatic step_sequencer(output css_res_t res);
    logic [15:0] period;
    logic        burst;
    burst = 1'b0;
    res.line_number = 10'(line_q);
    if (line_q <= VsyncLastLine) begin
      // vertical sync lines, line zero included
      ctl_q.mark = 1'b1;
      period = ctl_q.vert_step[0] ? cfg_q.vsync_period : cfg_q.half_sync_period;
      ctl_q.sync = ctl_q.vert_step[0];
      if (ctl_q.vert_step == VstepLast) line_q = line_q + 1'b1;
      ctl_q.vert_step = ctl_q.vert_step + 2'd1;
    end else if (line_q <= EqualLastLine) begin
      // equalizing lines
      ctl_q.mark = 1'b0;
      period = ctl_q.vert_step[0] ? cfg_q.hsync_period : cfg_q.vsync_period;
      ctl_q.sync = ctl_q.vert_step[0];
      if (ctl_q.vert_step == VstepLast) line_q = line_q + 1'b1;
      ctl_q.vert_step = ctl_q.vert_step + 2'd1;
    end else if (line_q <= FieldLastLine) begin
      // two steps per line, sync kept low on the second
      if (ctl_q.vert_step == VstepFirst) begin
        period = cfg_q.half_sync_period;
        ctl_q.sync = 1'b0;
        ctl_q.vert_step = VstepFirst + 2'd1;
      end else begin
        period = cfg_q.vsync_period;
        ctl_q.mark = 1'b1;
        ctl_q.vert_step = VstepFirst;
        line_q = line_q + 1'b1;
      end
    end else begin
      // picture lines: hsync, back porch, active part
      ctl_q.mark = 1'b0;
      case (ctl_q.horiz_step)
        HstepSync: begin
          period = cfg_q.hsync_period;
          ctl_q.sync = 1'b0;
          ctl_q.horiz_step = HstepPorch;
        end
        HstepPorch: begin
          period = cfg_q.back_porch_period;
          ctl_q.sync = 1'b1;
          ctl_q.horiz_step = HstepActive;
        end
        default: begin
          period = cfg_q.active_period;
          ctl_q.sync = 1'b1;
          burst = (line_q >= cfg_q.first_visible_line);
          ctl_q.horiz_step = HstepSync;
          if (line_q == cfg_q.last_line) line_q = LINE_BITS'(1);
          else line_q = line_q + 1'b1;
        end
      endcase
    end
    res.next_period = period;
    res.sync_level  = ctl_q.sync;
    res.field_mark  = ctl_q.mark;
    res.start_burst = burst;
  endtask

  // track config writes, predict on accepted ticks, check accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q = '{hsync_period: HsyncPeriodRst, half_sync_period: HalfSyncPeriodRst,
                vsync_period: VsyncPeriodRst, back_porch_period: BackPorchPeriodRst,
                active_period: ActivePeriodRst, first_visible_line: FirstVisLineRst,
                last_line: LastLineRst};
      line_q = LINE_BITS'(1);
      ctl_q = '{vert_step: VstepFirst, horiz_step: HstepSync, sync: 1'b0, mark: 1'b0};
      expected_steps.delete();
      mismatch_count_o = 0;
      steps_outstanding_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegHsyncPeriod:     cfg_q.hsync_period       = cfg_data_i;
          RegHalfSyncPeriod:  cfg_q.half_sync_period   = cfg_data_i;
          RegVsyncPeriod:     cfg_q.vsync_period       = cfg_data_i;
          RegBackPorchPeriod: cfg_q.back_porch_period  = cfg_data_i;
          RegActivePeriod:    cfg_q.active_period      = cfg_data_i;
          RegFirstVisLine:    cfg_q.first_visible_line = cfg_data_i[9:0];
          RegLastLine:        cfg_q.last_line          = cfg_data_i[9:0];
          default: ;
        endcase
      end
      // results first, so a result never pairs with a tick taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (expected_steps.size() == 0) begin
          report_mismatch("result with nothing expected", 1, 0);
        end else begin
          want_res = expected_steps.pop_front();
          if (next_period_i !== want_res.next_period)
            report_mismatch("next_period", next_period_i, want_res.next_period);
          if (sync_level_i !== want_res.sync_level)
            report_mismatch("sync_level", sync_level_i, want_res.sync_level);
          if (field_mark_i !== want_res.field_mark)
            report_mismatch("field_mark", field_mark_i, want_res.field_mark);
          if (start_burst_i !== want_res.start_burst)
            report_mismatch("start_burst", start_burst_i, want_res.start_burst);
          if (line_number_i !== want_res.line_number)
            report_mismatch("line_number", line_number_i, want_res.line_number);
        end
      end
      // an idle tick gives no result and leaves the state alone
      if (in_valid_i && in_ready_i && tick_i) begin
        step_sequencer(want_res);
        expected_steps.push_back(want_res);
      end
      steps_outstanding_o = expected_steps.size();
    end
  end

endmodule

[tb/tb_top.sv]
// Testbench top for composite_sync_sequencer_core: clock, reset, tick and config stimulus.
// Prediction and checking live in css_sync_checker; types come from css_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import css_pkg::*;

  localparam int unsigned ResetCycles = 7;
  localparam int unsigned HoldCycles  = 48;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned TailCycles  = 10;
  localparam int unsigned QuietLimit  = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        tick_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] next_period_o;
  logic        sync_level_o;
  logic        field_mark_o;
  logic        start_burst_o;
  logic [9:0]  line_number_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  int unsigned mismatch_count;
  int unsigned steps_outstanding;
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          rx_hold_req;

  always #4 clk_i = ~clk_i;

  composite_sync_sequencer_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .tick_i       (tick_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .next_period_o(next_period_o),
    .sync_level_o (sync_level_o),
    .field_mark_o (field_mark_o),
    .start_burst_o(start_burst_o),
    .line_number_o(line_number_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  css_sync_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .tick_i             (tick_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .next_period_i      (next_period_o),
    .sync_level_i       (sync_level_o),
    .field_mark_i       (field_mark_o),
    .start_burst_i      (start_burst_o),
    .line_number_i      (line_number_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .mismatch_count_o   (mismatch_count),
    .steps_outstanding_o(steps_outstanding)
  );

  // offer one tick item, optionally after random idle cycles; valid stays up
  task automatic send_tick(input logic tick);
    while (tx_idle_en && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    tick_i     <= tick;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic run_items(input int unsigned count, input int unsigned tick_pct);
    repeat (count) send_tick($urandom_range(99) < tick_pct);
  endtask

  // one register write; valid stays up for a following write
  task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic load_config(input logic [15:0] hsync, input logic [15:0] half_sync,
                             input logic [15:0] vsync, input logic [15:0] porch,
                             input logic [15:0] active, input logic [9:0] first_vis,
                             input logic [9:0] last);
    write_reg(RegHsyncPeriod, hsync);
    write_reg(RegHalfSyncPeriod, half_sync);
    write_reg(RegVsyncPeriod, vsync);
    write_reg(RegBackPorchPeriod, porch);
    write_reg(RegActivePeriod, active);
    write_reg(RegFirstVisLine, {6'd0, first_vis});
    write_reg(RegLastLine, {6'd0, last});
    cfg_valid_i <= 1'b0;
  endtask

  // stop offering, wait for every expected result, let idle ticks flush
  task automatic drain_results();
    in_valid_i <= 1'b0;
    wait (steps_outstanding == 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // result receiver: random stalls, or one long hold-off on request
  initial begin : receiver
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= !(rx_idle_en && $urandom_range(99) < 33);
      end
    end
  end

  // end the run when no channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    tick_i      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegHsyncPeriod;
    cfg_data_i  = '0;
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    rx_hold_req = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // default periods: idle ticks mixed into the start of the vertical interval
    for (int i = 0; i < 24; i++) send_tick(i % 10 != 0);
    drain_results();

    // zero periods, lowest visible line, short frames, no idling yet
    load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 10'd10, 10'd12);
    run_items(120, 80);
    drain_results();

    // full-scale periods, receiver held off while ticks keep coming
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd11, 10'd14);
    rx_hold_req = 1'b1;
    run_items(120, 80);
    drain_results();

    // random periods, visible line sometimes past the last line
    repeat (3) begin
      load_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)),
                  10'($urandom_range(10, 30)), 10'($urandom_range(10, 30)));
      run_items(70, 80);
      drain_results();
    end

    // climb above the short frames with the top line as the limit
    load_config(HsyncPeriodRst, HalfSyncPeriodRst, VsyncPeriodRst, BackPorchPeriodRst,
                ActivePeriodRst, FirstVisLineRst, 10'd1023);
    run_items(60, 100);
    drain_results();

    // limit now below the count: never met, so lines keep climbing past it
    load_config(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), 10'd1023, 10'd10);
    run_items(60, 100);
    drain_results();

    repeat (TailCycles) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/css_pkg.sv
design/css_step.sv
design/composite_sync_sequencer_core.sv
tb/css_sync_checker.sv
tb/tb_top.sv
